[hw/rtl/vrt_pkg.sv]
// Shared types and constants for the voxel ray traversal block.
// Used by the front (setup), the queue and the back (walker) modules.
package vrt_pkg;

    localparam int unsigned CoordW = 16;
    localparam int unsigned TimeW  = 32;
    localparam int unsigned DirW   = 18;
    localparam int unsigned OrgW   = 32;
    localparam int unsigned DistW  = 24;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // One set-up ray, handed from the front to the back.
    typedef struct packed {
        logic [2:0][CoordW-1:0] voxel;
        logic [2:0][TimeW-1:0]  ctime;
        logic [2:0][TimeW-1:0]  cstep;
        logic [2:0]             sign_neg;
        logic [DistW-1:0]       max_dist;
    } ray_setup_t;

endpackage

[hw/rtl/voxel_ray_traversal_3d.sv]
// Voxel ray traversal top level: front set-up, ray queue, voxel walker.
// The front sets up each axis in turn with a bit-serial division, skipped for
// an axis with zero direction; the walker then offers one voxel per cycle while
// m_tready accepts. The walker overlaps the next ray's set-up, so the front can
// take a new ray while the last one is still being walked.
// Reset: aresetn synchronous, active low, empties queue and idles both ends.
module voxel_ray_traversal_3d #(
    parameter int unsigned MAX_STEPS = 64,
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, max_distance, pad
    input  logic [175:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // has_voxel, voxel_x, voxel_y, voxel_z, face_axis, face_negative,
    // truncated, pad
    output logic [55:0]  m_tdata,
    output logic         m_tlast
);
    logic f_valid, f_ready, q_valid, q_ready;
    vrt_pkg::ray_setup_t f_ray, q_ray;

    vrt_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_org(s_tdata[95:0]), .in_dir(s_tdata[149:96]), .in_maxd(s_tdata[173:150]),
        .out_valid(f_valid), .out_ready(f_ready), .out_ray(f_ray)
    );

    vrt_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(f_valid), .in_ready(f_ready), .in_ray(f_ray),
        .out_valid(q_valid), .out_ready(q_ready), .out_ray(q_ray)
    );

    vrt_walk #(.MAX_STEPS(MAX_STEPS)) u_walk (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(q_valid), .in_ready(q_ready), .in_ray(q_ray),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_data(m_tdata), .out_last(m_tlast)
    );

    logic unused_pad;
    assign unused_pad = ^s_tdata[175:174];
endmodule

[hw/rtl/vrt_front.sv]
// Front end: accepts a ray and derives start voxel, step signs, crossing
// times and increments with one shared restoring divider. Uses vrt_pkg.
module vrt_front #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [3*vrt_pkg::OrgW-1:0]      in_org,
    input  logic [3*vrt_pkg::DirW-1:0]      in_dir,
    input  logic [vrt_pkg::DistW-1:0]       in_maxd,
    output logic                            out_valid,
    input  logic                            out_ready,
    output vrt_pkg::ray_setup_t             out_ray
);
    localparam int unsigned NumW  = 2*FRAC_BITS + 1;
    localparam int unsigned QW    = NumW;
    localparam int unsigned CntW  = $clog2(NumW + 1);
    localparam int unsigned ProdW = 64;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_MUL, S_NEXT, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic [1:0]              axis_reg, axis_next;
    logic [CntW-1:0]         cnt_reg, cnt_next;
    logic [NumW-1:0]         rem_reg, rem_next;
    logic [QW-1:0]           quo_reg, quo_next;
    logic [vrt_pkg::DirW-1:0] mag_reg, mag_next;
    logic [3*vrt_pkg::OrgW-1:0] org_reg, org_next;
    logic [3*vrt_pkg::DirW-1:0] dir_reg, dir_next;
    vrt_pkg::ray_setup_t     ray_reg, ray_next;

    logic [vrt_pkg::OrgW-1:0] org_a;
    logic [vrt_pkg::DirW-1:0] dir_a;
    logic [vrt_pkg::DirW-1:0] mag_a;
    logic                     neg_a;
    logic [FRAC_BITS:0]       frac_a, dist_a;
    logic [NumW:0]            trial;
    logic [vrt_pkg::TimeW-1:0] recip_sat;
    logic [ProdW-1:0]         prod;
    logic [ProdW-1:0]         prod_sh;
    logic [NumW-1:0]          num;

    always_comb begin
        org_a  = org_reg[axis_reg*vrt_pkg::OrgW +: vrt_pkg::OrgW];
        dir_a  = dir_reg[axis_reg*vrt_pkg::DirW +: vrt_pkg::DirW];
        neg_a  = dir_a[vrt_pkg::DirW-1];
        mag_a  = neg_a ? (~dir_a + 1'b1) : dir_a;
        frac_a = {1'b0, org_a[FRAC_BITS-1:0]};
        dist_a = (!neg_a && (mag_a != '0)) ? ((FRAC_BITS+1)'(1) << FRAC_BITS) - frac_a
                                           : frac_a;
        num    = NumW'(1) << (2*FRAC_BITS);
        trial  = {rem_reg, num[NumW-1 - cnt_reg]};
        recip_sat = (quo_reg > QW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                   : vrt_pkg::TimeW'(quo_reg);
        prod    = ProdW'(dist_a) * ProdW'(ray_reg.cstep[axis_reg]);
        prod_sh = prod >> FRAC_BITS;
    end

    always_comb begin
        state_next = state_reg;
        axis_next  = axis_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        mag_next   = mag_reg;
        org_next   = org_reg;
        dir_next   = dir_reg;
        ray_next   = ray_reg;
        in_ready   = (state_reg == S_IDLE);
        out_valid  = (state_reg == S_OUT);
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    org_next = in_org;
                    dir_next = in_dir;
                    ray_next.max_dist = in_maxd;
                    axis_next  = vrt_pkg::AXIS_X;
                    state_next = S_NEXT;
                end
            end
            S_NEXT: begin
                // load the axis: voxel, sign, and start its division unless its direction is zero
                ray_next.voxel[axis_reg] = org_a[vrt_pkg::OrgW-1 -: vrt_pkg::CoordW];
                ray_next.voxel[axis_reg] = vrt_pkg::CoordW'(
                    $signed(org_a) >>> FRAC_BITS);
                ray_next.sign_neg[axis_reg] = neg_a || (mag_a == '0);
                mag_next = mag_a;
                rem_next = '0;
                quo_next = '0;
                cnt_next = '0;
                if (mag_a == '0) begin
                    ray_next.cstep[axis_reg] = 32'hFFFF_FFFF;
                    ray_next.ctime[axis_reg] = 32'hFFFF_FFFF;
                    priority if (axis_reg == vrt_pkg::AXIS_Z) state_next = S_OUT;
                    else begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = S_NEXT;
                    end
                end else begin
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                // one quotient bit per cycle
                if (trial >= (NumW+1)'(mag_reg)) begin
                    rem_next = NumW'(trial - (NumW+1)'(mag_reg));
                    quo_next = {quo_reg[QW-2:0], 1'b1};
                end else begin
                    rem_next = NumW'(trial);
                    quo_next = {quo_reg[QW-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CntW'(NumW-1)) state_next = S_MUL;
            end
            S_MUL: begin
                if (cnt_reg == CntW'(NumW)) begin
                    ray_next.cstep[axis_reg] = recip_sat;
                    cnt_next = cnt_reg + 1'b1;
                end else begin
                    ray_next.ctime[axis_reg] = (prod_sh > ProdW'(32'hFFFF_FFFF))
                        ? 32'hFFFF_FFFF : vrt_pkg::TimeW'(prod_sh);
                    priority if (axis_reg == vrt_pkg::AXIS_Z) state_next = S_OUT;
                    else begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = S_NEXT;
                    end
                end
            end
            S_OUT: begin
                if (out_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        axis_reg <= axis_next;
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        mag_reg  <= mag_next;
        org_reg  <= org_next;
        dir_reg  <= dir_next;
        ray_reg  <= ray_next;
    end

    assign out_ray = ray_reg;

endmodule

[hw/rtl/vrt_queue.sv]
// Two-entry queue of set-up rays between front and back. Uses vrt_pkg.
module vrt_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  vrt_pkg::ray_setup_t in_ray,
    output logic                out_valid,
    input  logic                out_ready,
    output vrt_pkg::ray_setup_t out_ray
);
    vrt_pkg::ray_setup_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;
    assign out_ray = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) mem_reg[wp_reg] <= in_ray;
    end
endmodule

[hw/rtl/vrt_walk.sv]
// Back end: walks voxel by voxel, one step per cycle into an output
// register while that register is empty or being read. Uses vrt_pkg.
module vrt_walk #(
    parameter int unsigned MAX_STEPS = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  vrt_pkg::ray_setup_t in_ray,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [55:0]         out_data,
    output logic                out_last
);
    localparam int unsigned SW = $clog2(MAX_STEPS + 1);

    logic                busy_reg;
    vrt_pkg::ray_setup_t ray_reg;
    logic [SW-1:0]       left_reg;
    logic                ov_reg;
    logic [55:0]         od_reg;
    logic                ol_reg;

    vrt_pkg::ray_setup_t ray_cur, ray_next;
    logic [55:0]         od_next;
    logic [2:0][31:0] ct;
    logic [1:0] ax, nx;
    logic [31:0] nt;
    logic [32:0] sum;
    logic [2:0][31:0] ct2;
    logic [15:0] nv;
    logic stop, trunc, slot;

    function automatic logic [1:0] pick(input logic [2:0][31:0] t);
        logic [1:0] r;
        begin
            if (t[0] < t[1]) r = (t[0] < t[2]) ? vrt_pkg::AXIS_X : vrt_pkg::AXIS_Z;
            else r = (t[1] < t[2]) ? vrt_pkg::AXIS_Y : vrt_pkg::AXIS_Z;
            return r;
        end
    endfunction

    assign slot = !ov_reg || out_ready;
    assign in_ready = !busy_reg && slot;

    always_comb begin
        ray_cur = busy_reg ? ray_reg : in_ray;
        ct  = ray_cur.ctime;
        ax  = pick(ct);
        sum = {1'b0, ct[ax]} + {1'b0, ray_cur.cstep[ax]};
        nt  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        ct2 = ct;
        ct2[ax] = nt;
        nx  = pick(ct2);
        nv  = ray_cur.sign_neg[ax] ? ray_cur.voxel[ax] - 16'd1
                                   : ray_cur.voxel[ax] + 16'd1;
        ray_next = ray_cur;
        ray_next.ctime = ct2;
        ray_next.voxel[ax] = nv;
        stop  = ct2[nx] > 32'(ray_cur.max_dist);
        // budget: first step of a ray has MAX_STEPS-1 left after it
        trunc = !stop && (busy_reg ? (left_reg == SW'(1)) : (MAX_STEPS == 1));
        od_next = {3'b000, trunc, !ray_cur.sign_neg[ax], ax,
                   ray_next.voxel[2], ray_next.voxel[1], ray_next.voxel[0], 1'b1};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end else begin
            if (!busy_reg && in_valid && slot) begin
                ov_reg <= 1'b1;
                if (ct[ax] > 32'(in_ray.max_dist)) begin
                    od_reg <= '0;
                    ol_reg <= 1'b1;
                end else begin
                    ray_reg  <= ray_next;
                    left_reg <= SW'(MAX_STEPS - 1);
                    busy_reg <= !(stop || trunc);
                    od_reg   <= od_next;
                    ol_reg   <= stop || trunc;
                end
            end else if (busy_reg && slot) begin
                ov_reg   <= 1'b1;
                ray_reg  <= ray_next;
                left_reg <= left_reg - 1'b1;
                busy_reg <= !(stop || trunc);
                od_reg   <= od_next;
                ol_reg   <= stop || trunc;
            end else if (slot) begin
                ov_reg <= 1'b0;
            end
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;
    assign out_last  = ol_reg;
endmodule
